### design/ipr_pkg.sv
// Shared types and constants for the image packet reassembler.
`timescale 1ns / 1ps
`default_nettype none

package ipr_pkg;

    localparam int BYTE_W  = 8;
    localparam int WORD_W  = 16;
    localparam int POS_W   = 4;

    // Header layout, in report byte positions
    localparam logic [POS_W-1:0] POS_KEY      = 4'd2;
    localparam logic [POS_W-1:0] POS_LAST     = 4'd3;
    localparam logic [POS_W-1:0] POS_LEN_LO   = 4'd4;
    localparam logic [POS_W-1:0] POS_LEN_HI   = 4'd5;
    localparam logic [POS_W-1:0] POS_SEQ_LO   = 4'd6;
    localparam logic [POS_W-1:0] POS_SEQ_HI   = 4'd7;
    localparam logic [POS_W-1:0] HEADER_BYTES = 4'd8;

    localparam logic [WORD_W-1:0] BMP_HEADER_BYTES = 16'd54;
    localparam logic [WORD_W-1:0] BMP_MAGIC        = 16'h4D42;

    typedef enum logic [2:0] {
        ST_CHUNK     = 3'd0,
        ST_COMPLETE  = 3'd1,
        ST_SHORT     = 3'd2,
        ST_BAD_KEY   = 3'd3,
        ST_SEQ_ERROR = 3'd4,
        ST_OVERFLOW  = 3'd5
    } status_t;

    typedef struct packed {
        status_t           status;
        logic [BYTE_W-1:0] key_id;
        logic [WORD_W-1:0] received_sequence;
        logic [WORD_W-1:0] byte_total;
        logic              has_bmp_header;
    } result_t;

endpackage

`default_nettype wire

### design/image_packet_reassembler_unit.sv
// Top level of the image packet reassembler.
// Takes one report byte per cycle, back to back, with report_end on the last byte of each
// report. Every byte is registered at the input, then decoded and applied to the per-key
// state and the image store; the per-key read-modify-write sets the rate of one byte per
// cycle. When a report's last byte leaves the input register, its status transaction is
// loaded into the result register that drives the m_ side. Bytes that end no report keep flowing
// while a status waits; the final byte of a report waits only while the result register
// still holds an untaken status. The image store is written only and needs no clearing
// pass, so the block accepts bytes from the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none

module image_packet_reassembler_unit #(
    parameter int KEY_COUNT    = 6,
    parameter int BUFFER_BYTES = 32768
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [ipr_pkg::BYTE_W-1:0] s_report_byte,
    input  wire logic                       s_report_end,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic [2:0]                      m_status,
    output logic [ipr_pkg::BYTE_W-1:0]      m_key_index,
    output logic [ipr_pkg::WORD_W-1:0]      m_received_sequence,
    output logic [ipr_pkg::WORD_W-1:0]      m_byte_total,
    output logic                            m_has_bmp_header
);

    logic                       item_valid;
    logic [ipr_pkg::BYTE_W-1:0] item_byte;
    logic                       item_end;
    logic                       slot_free;
    logic                       step_en;
    ipr_pkg::result_t           result;

    // a report end needs room in the result register
    assign step_en = item_valid && (!item_end || slot_free);

    ipr_input_stage u_input (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_report_byte (s_report_byte),
        .s_report_end  (s_report_end),
        .pop           (step_en),
        .item_valid    (item_valid),
        .item_byte     (item_byte),
        .item_end      (item_end)
    );

    ipr_core #(
        .KEY_COUNT    (KEY_COUNT),
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step_en),
        .byte_i  (item_byte),
        .end_i   (item_end),
        .result  (result)
    );

    ipr_output_stage u_output (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .load                (step_en && item_end),
        .result              (result),
        .slot_free           (slot_free),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_status            (m_status),
        .m_key_index         (m_key_index),
        .m_received_sequence (m_received_sequence),
        .m_byte_total        (m_byte_total),
        .m_has_bmp_header    (m_has_bmp_header)
    );

endmodule

`default_nettype wire

### design/ipr_input_stage.sv
// Input register for report bytes, with ready derived from the downstream step.
`timescale 1ns / 1ps
`default_nettype none

module ipr_input_stage (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic [ipr_pkg::BYTE_W-1:0] s_report_byte,
    input  wire logic                      s_report_end,
    input  wire logic                      pop,
    output logic                           item_valid,
    output logic [ipr_pkg::BYTE_W-1:0]     item_byte,
    output logic                           item_end
);

    logic                       valid_reg;
    logic [ipr_pkg::BYTE_W-1:0] byte_reg;
    logic                       end_reg;

    assign s_ready    = !valid_reg || pop;
    assign item_valid = valid_reg;
    assign item_byte  = byte_reg;
    assign item_end   = end_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            byte_reg <= s_report_byte;
            end_reg  <= s_report_end;
        end
    end

endmodule

`default_nettype wire

### design/ipr_core.sv
// Header decode, per-key bookkeeping, image store writes and report status.
`timescale 1ns / 1ps
`default_nettype none

module ipr_core #(
    parameter int KEY_COUNT    = 6,
    parameter int BUFFER_BYTES = 32768
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       step_en,
    input  wire logic [ipr_pkg::BYTE_W-1:0] byte_i,
    input  wire logic                       end_i,
    output ipr_pkg::result_t                result
);

    localparam int KEY_W       = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
    localparam int STORE_DEPTH = KEY_COUNT * BUFFER_BYTES;
    localparam int STORE_AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int ADDR_W      = ipr_pkg::WORD_W + 1;

    localparam logic [ipr_pkg::BYTE_W:0]   KEY_LIMIT  = (ipr_pkg::BYTE_W + 1)'(KEY_COUNT);
    localparam logic [ADDR_W-1:0]          ADDR_LIMIT = ADDR_W'(BUFFER_BYTES);
    localparam logic [ipr_pkg::WORD_W-1:0] FULL_FILL  = ipr_pkg::WORD_W'(BUFFER_BYTES);

    // per-report registers
    logic [ipr_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic [ipr_pkg::BYTE_W-1:0] key_reg, key_next;
    logic                       last_reg, last_next;
    logic [ipr_pkg::WORD_W-1:0] len_reg, len_next;
    logic [ipr_pkg::WORD_W-1:0] seq_reg, seq_next;
    logic [ipr_pkg::WORD_W-1:0] taken_reg, taken_next;
    ipr_pkg::status_t           verdict_reg, verdict_next;

    // per-key registers
    logic [ipr_pkg::WORD_W-1:0] fill_reg [KEY_COUNT];
    logic [ipr_pkg::WORD_W-1:0] nseq_reg [KEY_COUNT];
    logic                       recv_reg [KEY_COUNT];
    logic [ipr_pkg::WORD_W-1:0] lead_reg [KEY_COUNT];

    logic [ipr_pkg::WORD_W-1:0] fill_next, nseq_next, lead_next;
    logic                       recv_next;
    logic                       entry_we;

    logic [7:0] image_mem [STORE_DEPTH];

    logic [KEY_W-1:0]           kidx;
    logic                       key_ok;
    logic                       payload_en;
    logic                       store_en;
    logic [ADDR_W-1:0]          addr;
    logic [STORE_AW-1:0]        mem_addr;
    logic [ipr_pkg::WORD_W-1:0] space;
    logic [ipr_pkg::WORD_W-1:0] sum;

    always_comb begin
        key_next     = key_reg;
        last_next    = last_reg;
        len_next     = len_reg;
        seq_next     = seq_reg;
        pos_next     = pos_reg;
        taken_next   = taken_reg;
        verdict_next = verdict_reg;
        if (pos_reg < ipr_pkg::HEADER_BYTES) begin
            pos_next = pos_reg + 4'd1;
            case (pos_reg)
                ipr_pkg::POS_KEY:    key_next       = byte_i;
                ipr_pkg::POS_LAST:   last_next      = (byte_i != 8'd0);
                ipr_pkg::POS_LEN_LO: len_next[7:0]  = byte_i;
                ipr_pkg::POS_LEN_HI: len_next[15:8] = byte_i;
                ipr_pkg::POS_SEQ_LO: seq_next[7:0]  = byte_i;
                ipr_pkg::POS_SEQ_HI: seq_next[15:8] = byte_i;
                default: ;
            endcase
        end

        kidx   = key_next[KEY_W-1:0];
        key_ok = {1'b0, key_next} < KEY_LIMIT;

        fill_next = fill_reg[kidx];
        nseq_next = nseq_reg[kidx];
        recv_next = recv_reg[kidx];
        lead_next = lead_reg[kidx];

        // header judgment on its last byte
        if (pos_reg == ipr_pkg::POS_SEQ_HI) begin
            if (!key_ok) begin
                verdict_next = ipr_pkg::ST_BAD_KEY;
            end else if (seq_next == 16'd0) begin
                fill_next    = '0;
                nseq_next    = '0;
                recv_next    = 1'b1;
                lead_next    = '0;
                verdict_next = ipr_pkg::ST_CHUNK;
            end else if (!recv_next || seq_next != nseq_next) begin
                fill_next    = '0;
                nseq_next    = '0;
                recv_next    = 1'b0;
                lead_next    = '0;
                verdict_next = ipr_pkg::ST_SEQ_ERROR;
            end else begin
                verdict_next = ipr_pkg::ST_CHUNK;
            end
        end

        payload_en = (pos_reg == ipr_pkg::HEADER_BYTES) &&
                     (verdict_reg == ipr_pkg::ST_CHUNK) && (taken_reg < len_reg);
        addr       = {1'b0, fill_next} + {1'b0, taken_reg};
        store_en   = payload_en && (addr < ADDR_LIMIT);
        mem_addr   = STORE_AW'(kidx) * STORE_AW'(BUFFER_BYTES) + STORE_AW'(addr);
        if (store_en && addr == 17'd0) begin
            lead_next[7:0] = byte_i;
        end else if (store_en && addr == 17'd1) begin
            lead_next[15:8] = byte_i;
        end
        if (payload_en) begin
            taken_next = taken_reg + 16'd1;
        end

        space = FULL_FILL - fill_next;
        sum   = fill_next + taken_next;

        result = '{status: ipr_pkg::ST_SHORT, key_id: '0, received_sequence: '0,
                   byte_total: '0, has_bmp_header: 1'b0};
        if (end_i && pos_reg >= ipr_pkg::POS_SEQ_HI) begin
            result.key_id            = key_next;
            result.received_sequence = seq_next;
            if (verdict_next != ipr_pkg::ST_CHUNK) begin
                result.status = verdict_next;
            end else if (taken_next > space) begin
                fill_next     = '0;
                nseq_next     = '0;
                recv_next     = 1'b0;
                lead_next     = '0;
                result.status = ipr_pkg::ST_OVERFLOW;
            end else begin
                result.byte_total = sum;
                if (last_next) begin
                    result.has_bmp_header = (sum > ipr_pkg::BMP_HEADER_BYTES) &&
                                            (lead_next == ipr_pkg::BMP_MAGIC);
                    fill_next     = '0;
                    nseq_next     = '0;
                    recv_next     = 1'b0;
                    lead_next     = '0;
                    result.status = ipr_pkg::ST_COMPLETE;
                end else begin
                    fill_next     = sum;
                    nseq_next     = nseq_next + 16'd1;
                    result.status = ipr_pkg::ST_CHUNK;
                end
            end
        end

        entry_we = key_ok && (pos_reg >= ipr_pkg::POS_SEQ_HI);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            key_reg     <= '0;
            last_reg    <= 1'b0;
            len_reg     <= '0;
            seq_reg     <= '0;
            taken_reg   <= '0;
            verdict_reg <= ipr_pkg::ST_CHUNK;
            for (int i = 0; i < KEY_COUNT; i++) begin
                fill_reg[i] <= '0;
                nseq_reg[i] <= '0;
                recv_reg[i] <= 1'b0;
                lead_reg[i] <= '0;
            end
        end else if (step_en) begin
            if (end_i) begin
                pos_reg     <= '0;
                key_reg     <= '0;
                last_reg    <= 1'b0;
                len_reg     <= '0;
                seq_reg     <= '0;
                taken_reg   <= '0;
                verdict_reg <= ipr_pkg::ST_CHUNK;
            end else begin
                pos_reg     <= pos_next;
                key_reg     <= key_next;
                last_reg    <= last_next;
                len_reg     <= len_next;
                seq_reg     <= seq_next;
                taken_reg   <= taken_next;
                verdict_reg <= verdict_next;
            end
            if (entry_we) begin
                fill_reg[kidx] <= fill_next;
                nseq_reg[kidx] <= nseq_next;
                recv_reg[kidx] <= recv_next;
                lead_reg[kidx] <= lead_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en && store_en) begin
            image_mem[mem_addr] <= byte_i;
        end
    end

endmodule

`default_nettype wire

### design/ipr_output_stage.sv
// Result register holding one status transaction until it is taken.
`timescale 1ns / 1ps
`default_nettype none

module ipr_output_stage (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        load,
    input  wire ipr_pkg::result_t            result,
    output logic                             slot_free,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [2:0]                       m_status,
    output logic [ipr_pkg::BYTE_W-1:0]       m_key_index,
    output logic [ipr_pkg::WORD_W-1:0]       m_received_sequence,
    output logic [ipr_pkg::WORD_W-1:0]       m_byte_total,
    output logic                             m_has_bmp_header
);

    logic             valid_reg;
    ipr_pkg::result_t result_reg;

    assign slot_free           = !valid_reg || m_ready;
    assign m_valid             = valid_reg;
    assign m_status            = result_reg.status;
    assign m_key_index         = result_reg.key_id;
    assign m_received_sequence = result_reg.received_sequence;
    assign m_byte_total        = result_reg.byte_total;
    assign m_has_bmp_header    = result_reg.has_bmp_header;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (slot_free) begin
            valid_reg <= load;
        end
        if (load && slot_free) begin
            result_reg <= result;
        end
    end

endmodule

`default_nettype wire
